// ===== hw/rtl/fpc_pkg.sv =====
// ----------------------------------------------------------------------------
// fpc_pkg
// Shared types and constants for the frequent pattern word compressor.
// ----------------------------------------------------------------------------
package fpc_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned PrefixW = 3;
  localparam int unsigned BitsW   = 6;
  localparam int unsigned OutW    = PrefixW + WordW + BitsW;
  localparam int unsigned OutPadW = ((OutW + 7) / 8) * 8;

  typedef enum logic [PrefixW-1:0] {
    PAT_ZERO   = 3'b000,
    PAT_SEXT4  = 3'b001,
    PAT_SEXT8  = 3'b010,
    PAT_SEXT16 = 3'b011,
    PAT_LOZERO = 3'b100,
    PAT_HBYTES = 3'b101,
    PAT_REPB   = 3'b110,
    PAT_RAW    = 3'b111
  } pattern_t;

  localparam logic [BitsW-1:0] Bits0  = 6'd0;
  localparam logic [BitsW-1:0] Bits4  = 6'd4;
  localparam logic [BitsW-1:0] Bits8  = 6'd8;
  localparam logic [BitsW-1:0] Bits16 = 6'd16;
  localparam logic [BitsW-1:0] Bits32 = 6'd32;

  typedef struct packed {
    pattern_t           prefix;
    logic [WordW-1:0]   payload;
    logic [BitsW-1:0]   payload_bits;
  } result_t;

endpackage

// ===== hw/rtl/fpc_classify.sv =====
// ----------------------------------------------------------------------------
// fpc_classify
// Matches one word against the frequent patterns and forms prefix and payload.
// ----------------------------------------------------------------------------
module fpc_classify
  import fpc_pkg::*;
(
  input  logic [WordW-1:0] data_word,
  output result_t          res
);

  logic fit4;
  logic fit8;
  logic fit16;
  logic lo_zero;
  logic hi_sext;
  logic lo_sext;
  logic rep_byte;

  always_comb begin
    fit4     = (data_word[31:3] == '0) || (&data_word[31:3]);
    fit8     = (data_word[31:7] == '0) || (&data_word[31:7]);
    fit16    = (data_word[31:15] == '0) || (&data_word[31:15]);
    lo_zero  = (data_word[15:0] == '0);
    hi_sext  = (data_word[31:23] == '0) || (&data_word[31:23]);
    lo_sext  = (data_word[15:7] == '0) || (&data_word[15:7]);
    rep_byte = (data_word[15:8] == data_word[7:0]) &&
               (data_word[23:16] == data_word[7:0]) &&
               (data_word[31:24] == data_word[7:0]);
  end

  always_comb begin
    if (data_word == '0) begin
      res = '{prefix: PAT_ZERO, payload: '0, payload_bits: Bits0};
    end else if (fit4) begin
      res = '{prefix: PAT_SEXT4, payload: {28'd0, data_word[3:0]}, payload_bits: Bits4};
    end else if (fit8) begin
      res = '{prefix: PAT_SEXT8, payload: {24'd0, data_word[7:0]}, payload_bits: Bits8};
    end else if (fit16) begin
      res = '{prefix: PAT_SEXT16, payload: {16'd0, data_word[15:0]},
              payload_bits: Bits16};
    end else if (lo_zero) begin
      res = '{prefix: PAT_LOZERO, payload: {16'd0, data_word[31:16]},
              payload_bits: Bits16};
    end else if (hi_sext && lo_sext) begin
      res = '{prefix: PAT_HBYTES, payload: {16'd0, data_word[23:16], data_word[7:0]},
              payload_bits: Bits16};
    end else if (rep_byte) begin
      res = '{prefix: PAT_REPB, payload: {24'd0, data_word[7:0]}, payload_bits: Bits8};
    end else begin
      res = '{prefix: PAT_RAW, payload: data_word, payload_bits: Bits32};
    end
  end

endmodule

// ===== hw/rtl/fpc_word_compressor.sv =====
// ----------------------------------------------------------------------------
// fpc_word_compressor
// Frequent pattern compression of a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Each input transaction carries one word and yields exactly one output
// transaction with the 3-bit pattern code, the right-aligned payload and its
// length in bits. The block takes one word per clock cycle while the output
// is not stalled and delivers its result via the input register and then the
// result register; the rate is set by the combinational pattern match between
// those two registers. A stalled output holds its result while an empty input
// register still takes the next word.
module fpc_word_compressor
  import fpc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [WordW-1:0]   s_tdata,   // [31:0] data_word
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OutPadW-1:0] m_tdata    // [2:0] prefix, [34:3] payload,
                                        // [40:35] payload_bits, [47:41] zero
);

  logic             in_valid;
  logic [WordW-1:0] in_word;
  logic             out_valid;
  result_t          out_res;
  result_t          res_next;
  logic             advance;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  fpc_classify u_classify (
    .data_word (in_word),
    .res       (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_word <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OutPadW - OutW){1'b0}}, out_res.payload_bits,
                     out_res.payload, out_res.prefix};

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed or vanished");

  a_item_moves: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("accepted word did not reach the result register");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> s_tready)
    else $error("empty input register refused a word");

  a_payload_width: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ((out_res.payload >> out_res.payload_bits) == '0))
    else $error("payload has bits above its stated length");

  a_zero_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_res.prefix == PAT_ZERO |->
      out_res.payload == '0 && out_res.payload_bits == Bits0)
    else $error("zero word result carries payload");
`endif

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking stream test of the frequent pattern word compressor.
// ----------------------------------------------------------------------------
// Words go in through the input stream and every accepted transaction is
// classified by a local pattern predictor. Each output transaction is checked
// field by field against the oldest prediction. Directed corner words, forced
// output stalls, drained bursts and a long random stream with random gaps on
// both sides are run in turn.
module testbench
  import fpc_pkg::*;
;

  localparam int unsigned CycleLimit  = 400000;
  localparam int unsigned RandomWords = 900;
  localparam int unsigned SegmentLen  = 60;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned MaxPrinted  = 40;

  localparam logic [WordW-1:0] CornerWords [24] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0007, 32'hFFFF_FFF8,
    32'hFFFF_FFFF, 32'h0000_0008, 32'hFFFF_FFF7, 32'h0000_007F,
    32'hFFFF_FF80, 32'h0000_0080, 32'hFFFF_FF7F, 32'h0000_7FFF,
    32'hFFFF_8000, 32'h0000_8000, 32'hFFFF_7FFF, 32'h8000_0000,
    32'h1234_0000, 32'hFFFF_0000, 32'h007F_FF80, 32'hFF80_0001,
    32'h5555_5555, 32'h8080_8080, 32'h7FFF_FFFF, 32'hDEAD_BEEF
  };

  typedef struct {
    logic [WordW-1:0] word;
    pattern_t         prefix;
    logic [WordW-1:0] payload;
    logic [BitsW-1:0] payload_bits;
  } code_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [WordW-1:0]   s_tdata = '0;  // [31:0] data_word
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OutPadW-1:0] m_tdata;       // [2:0] prefix, [34:3] payload,
                                     // [40:35] payload_bits, [47:41] zero

  code_t       code_q [$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_hold = 0;
  int unsigned rx_gap = 0;
  bit          tx_idle_en = 1'b0;
  bit          rx_idle_en = 1'b0;

  fpc_word_compressor u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic code_t compress_word(input logic [WordW-1:0] w);
    code_t       c;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [7:0]  b0;
    hi = w[31:16];
    lo = w[15:0];
    b0 = w[7:0];
    c.word = w;
    if (w == '0) begin
      c.prefix = PAT_ZERO;   c.payload = '0;                  c.payload_bits = Bits0;
    end else if (w == {{28{w[3]}}, w[3:0]}) begin
      c.prefix = PAT_SEXT4;  c.payload = {28'd0, w[3:0]};     c.payload_bits = Bits4;
    end else if (w == {{24{w[7]}}, b0}) begin
      c.prefix = PAT_SEXT8;  c.payload = {24'd0, b0};         c.payload_bits = Bits8;
    end else if (w == {{16{w[15]}}, lo}) begin
      c.prefix = PAT_SEXT16; c.payload = {16'd0, lo};         c.payload_bits = Bits16;
    end else if (lo == '0) begin
      c.prefix = PAT_LOZERO; c.payload = {16'd0, hi};         c.payload_bits = Bits16;
    end else if (hi == {{8{hi[7]}}, hi[7:0]} && lo == {{8{lo[7]}}, lo[7:0]}) begin
      c.prefix = PAT_HBYTES; c.payload = {16'd0, hi[7:0], b0}; c.payload_bits = Bits16;
    end else if (w == {4{b0}}) begin
      c.prefix = PAT_REPB;   c.payload = {24'd0, b0};         c.payload_bits = Bits8;
    end else begin
      c.prefix = PAT_RAW;    c.payload = w;                   c.payload_bits = Bits32;
    end
    return c;
  endfunction

  // Builds a word aimed at one pattern; wider patterns may still land on a
  // lower code, which the predictor resolves.
  function automatic logic [WordW-1:0] make_word(input pattern_t p);
    logic [WordW-1:0] r;
    r = $urandom;
    case (p)
      PAT_ZERO:   return '0;
      PAT_SEXT4:  return {{28{r[3]}}, r[3:0]};
      PAT_SEXT8:  return {{24{r[7]}}, r[7:0]};
      PAT_SEXT16: return {{16{r[15]}}, r[15:0]};
      PAT_LOZERO: return {r[31:16], 16'd0};
      PAT_HBYTES: return {{8{r[23]}}, r[23:16], {8{r[7]}}, r[7:0]};
      PAT_REPB:   return {4{r[7:0]}};
      default:    return r;
    endcase
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string field, input logic [WordW-1:0] word,
                                 input logic [WordW-1:0] got,
                                 input logic [WordW-1:0] want);
    if (error_count < MaxPrinted) begin
      $display("%0t ns: %s mismatch for word %08h: got %0h, expected %0h",
               $time, field, word, got, want);
    end
    error_count++;
  endtask

  task automatic check_result(input logic [OutPadW-1:0] data);
    code_t want;
    if (code_q.size() == 0) begin
      report_mismatch("unexpected transaction", '0, data[34:3], '0);
    end else begin
      want = code_q.pop_front();
      if (data[2:0] != want.prefix)
        report_mismatch("prefix", want.word, WordW'(data[2:0]), WordW'(want.prefix));
      if (data[34:3] != want.payload)
        report_mismatch("payload", want.word, data[34:3], want.payload);
      if (data[40:35] != want.payload_bits)
        report_mismatch("payload_bits", want.word, WordW'(data[40:35]),
                        WordW'(want.payload_bits));
      if (data[47:41] != '0)
        report_mismatch("padding", want.word, WordW'(data[47:41]), '0);
    end
  endtask

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) code_q.insert(code_q.size(), compress_word(s_tdata));
      if (m_tvalid && m_tready) check_result(m_tdata);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    wait (rst == 1'b0);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        m_tready = 1'b0;
        rx_gap--;
      end else begin
        m_tready = 1'b1;
        if (rx_idle_en) rx_gap = pick_gap();
      end
    end
  end

  // Called and returning at a falling edge.
  task automatic send_word(input logic [WordW-1:0] w);
    int unsigned gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) s_tvalid = 1'b0;
    repeat (gap) begin
      s_tdata = $urandom;
      @(negedge clk);
    end
    s_tdata  = w;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (code_q.size() != 0) @(negedge clk);
  endtask

  task automatic test_corner_words();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    foreach (CornerWords[i]) send_word(CornerWords[i]);
    wait_drained();
  endtask

  task automatic test_output_stall();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    rx_hold = 200;
    repeat (40) send_word(make_word(pattern_t'($urandom_range(0, 7))));
    wait_drained();
  endtask

  task automatic test_drained_bursts();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    repeat (10) begin
      repeat ($urandom_range(1, 8)) send_word(make_word(pattern_t'($urandom_range(0, 7))));
      wait_drained();
    end
  endtask

  task automatic test_random_stream();
    for (int unsigned n = 0; n < RandomWords; n++) begin
      if (n % SegmentLen == 0) begin
        tx_idle_en = ($urandom_range(0, 3) != 0);
        rx_idle_en = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 3) == 0) send_word($urandom);
      else send_word(make_word(pattern_t'($urandom_range(0, 7))));
    end
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_corner_words();
    test_output_stall();
    test_drained_bursts();
    test_random_stream();
    repeat (SettleCycles) @(posedge clk);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/fpc_pkg.sv
hw/rtl/fpc_classify.sv
hw/rtl/fpc_word_compressor.sv
tb/testbench.sv
